### design/assert_macros.svh
// assertion macros used by the console top level
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tccs_pkg.sv
// shared types and constants for the text console
// used by the front end, queue, back end and top level; no dependencies
package tccs_pkg;

    // field widths of the ports
    localparam int OP_W       = 2;
    localparam int CP_W       = 21;
    localparam int RSEL_W     = 5;
    localparam int CSEL_W     = 7;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 32;
    localparam int CUR_COL_W  = 7;
    localparam int CUR_ROW_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // row and column fields in a command, wide enough for the largest grid
    localparam int ROW_AW = 6;
    localparam int COL_AW = 8;

    // one cell in memory: character, foreground, background
    localparam int CELL_W = CHAR_W + 2 * COLOR_W;

    localparam int QUEUE_DEPTH = 2;

    // register reset values
    localparam logic [5:0]         ROWS_RESET = 6'd26;
    localparam logic [7:0]         COLS_RESET = 8'd68;
    localparam logic [COLOR_W-1:0] TEXT_RESET = 32'h00FF_00FF;
    localparam logic [COLOR_W-1:0] BACK_RESET = 32'h0000_0000;

    // special characters
    localparam logic [CP_W-1:0]   CP_TAB    = 21'd9;
    localparam logic [CP_W-1:0]   CP_RETURN = 21'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'd32;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS = 2'd0,
        REG_COLS = 2'd1,
        REG_TEXT = 2'd2,
        REG_BACK = 2'd3
    } t_reg;

    // grid-wide work that follows a request
    typedef enum logic [1:0] {
        SW_NONE   = 2'd0,
        SW_SCROLL = 2'd1,
        SW_CLEAR  = 2'd2
    } t_sweep;

    // back end sequencer states
    typedef enum logic [2:0] {
        BS_INIT  = 3'd0,
        BS_IDLE  = 3'd1,
        BS_COPY  = 3'd2,
        BS_ZERO  = 3'd3,
        BS_CLEAR = 3'd4,
        BS_DONE  = 3'd5
    } t_bstate;

    // classified request passed from front end to back end
    typedef struct packed {
        logic                 wr;
        logic                 rd;
        t_sweep               sweep;
        logic [ROW_AW-1:0]    row;
        logic [COL_AW-1:0]    col;
        logic [CHAR_W-1:0]    ch;
        logic [COLOR_W-1:0]   fore;
        logic [COLOR_W-1:0]   back;
        logic [CUR_COL_W-1:0] cur_col;
        logic [CUR_ROW_W-1:0] cur_row;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic init_done;
        logic pop;
    } t_back_stat;

endpackage

### design/tccs_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tccs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, read returns the old data on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/tccs_front.sv
// front end: accepts requests, tracks the cursor and classifies each request
// into a command for the back end; uses tccs_pkg
module tccs_front import tccs_pkg::*; #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 128,
    localparam int RCW = $clog2(MAX_ROWS + 1),
    localparam int CCW = $clog2(MAX_COLS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_opcode,
    input  logic [CP_W-1:0]    i_code_point,
    input  logic [RSEL_W-1:0]  i_row_sel,
    input  logic [CSEL_W-1:0]  i_col_sel,
    input  logic [RCW-1:0]     i_rows,
    input  logic [CCW-1:0]     i_cols,
    input  logic [COLOR_W-1:0] i_text_color,
    input  logic [COLOR_W-1:0] i_back_color,
    input  t_q_stat            i_q_stat,
    input  logic               i_init_done,
    output logic               o_push,
    output t_cmd               o_cmd
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int XW  = $clog2(MAX_COLS);
    localparam int XTW = $clog2(MAX_COLS + 4);
    localparam int RST_ROWS = (int'(ROWS_RESET) > MAX_ROWS) ? MAX_ROWS : int'(ROWS_RESET);
    localparam logic [RW-1:0] RST_Y = RW'(RST_ROWS - 1);

    logic [XW-1:0]     r_cur_x, n_x;
    logic [RW-1:0]     r_cur_y, n_y;
    logic [XTW-1:0]    x_ext, tab_sum, tab_x, inc_x, adv_x;
    logic              wrap, cur_in, sel_in;
    logic [CHAR_W-1:0] ch;
    logic [31:0]       cx, cy;
    t_cmd              cmd;

    // accept only after the grid is cleared and while the queue has room
    assign o_ready = !i_q_stat.full && i_init_done;
    assign o_push  = i_valid && o_ready;
    assign o_cmd   = cmd;

    // cursor update and command classification
    always_comb begin
        n_x     = r_cur_x;
        n_y     = r_cur_y;
        cmd     = '0;
        wrap    = 1'b0;
        x_ext   = XTW'(r_cur_x);
        tab_sum = x_ext + XTW'(3);
        tab_x   = {tab_sum[XTW-1:2], 2'b00};
        inc_x   = x_ext + XTW'(1);
        adv_x   = inc_x;
        cur_in  = (32'(r_cur_y) < 32'(i_rows)) && (32'(r_cur_x) < 32'(i_cols));
        sel_in  = (32'(i_row_sel) < 32'(i_rows)) && (32'(i_col_sel) < 32'(i_cols));
        ch      = (i_code_point[CHAR_W-1:0] == CH_SPACE) ? '0 : i_code_point[CHAR_W-1:0];

        cmd.ch   = ch;
        cmd.fore = i_text_color;
        cmd.back = i_back_color;

        unique case (t_op'(i_opcode))
            OP_PUT: begin
                cmd.row = ROW_AW'(r_cur_y);
                cmd.col = COL_AW'(r_cur_x);
                priority if (i_code_point == CP_TAB) begin
                    adv_x = tab_x;
                    wrap  = (tab_x >= XTW'(i_cols));
                end else if (i_code_point == CP_RETURN) begin
                    wrap = 1'b1;
                end else begin
                    cmd.wr = cur_in;
                    wrap   = (inc_x >= XTW'(i_cols));
                end
                // wrap moves down a row, or scrolls from the bottom row
                if (wrap) begin
                    n_x = '0;
                    if (r_cur_y == '0) begin
                        cmd.sweep = SW_SCROLL;
                    end else begin
                        n_y = r_cur_y - RW'(1);
                    end
                end else begin
                    n_x = adv_x[XW-1:0];
                end
            end
            OP_WRITE: begin
                cmd.row = ROW_AW'(i_row_sel);
                cmd.col = COL_AW'(i_col_sel);
                cmd.wr  = sel_in;
            end
            OP_CLEAR: begin
                cmd.sweep = SW_CLEAR;
                n_x       = '0;
                n_y       = RW'(i_rows - RCW'(1));
            end
            OP_READ: begin
                cmd.row = ROW_AW'(i_row_sel);
                cmd.col = COL_AW'(i_col_sel);
                cmd.rd  = sel_in;
            end
        endcase

        // reported cursor is masked to the port widths
        cx          = 32'(n_x);
        cy          = 32'(n_y);
        cmd.cur_col = cx[CUR_COL_W-1:0];
        cmd.cur_row = cy[CUR_ROW_W-1:0];
    end

    // cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= RST_Y;
        end else if (o_push) begin
            r_cur_x <= n_x;
            r_cur_y <= n_y;
        end
    end

endmodule

### design/tccs_queue.sv
// short command queue between front end and back end
// uses tccs_pkg for the command type and depth
module tccs_queue import tccs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [IW-1:0] r_rd, r_wr;
    logic [CW-1:0] r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == IW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + IW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == IW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + IW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### design/tccs_back.sv
// back end: sequencer that owns the cell memory and runs writes, reads,
// scroll, clear and the reset clearing pass; uses tccs_pkg and tccs_ram
module tccs_back import tccs_pkg::*; #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 128,
    localparam int RCW = $clog2(MAX_ROWS + 1),
    localparam int CCW = $clog2(MAX_COLS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_head,
    input  t_q_stat              i_q_stat,
    input  logic [RCW-1:0]       i_rows,
    input  logic [CCW-1:0]       i_cols,
    output t_back_stat           o_stat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CHAR_W-1:0]    o_cell_char,
    output logic [COLOR_W-1:0]   o_cell_fore,
    output logic [COLOR_W-1:0]   o_cell_back,
    output logic [CUR_COL_W-1:0] o_cursor_col,
    output logic [CUR_ROW_W-1:0] o_cursor_row,
    output logic                 o_did_scroll
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int XW    = $clog2(MAX_COLS);
    localparam int CELLS = MAX_ROWS * (2 ** XW);
    localparam int AW    = $clog2(CELLS);

    t_bstate              r_state, n_state;
    logic [RW-1:0]        r_row, n_row;
    logic [XW-1:0]        r_col, n_col;
    t_cmd                 r_cmd, n_cmd;
    logic                 r_wpend, n_wpend;
    logic [AW-1:0]        r_waddr, n_waddr;
    logic                 r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]    r_out_char, n_out_char;
    logic [COLOR_W-1:0]   r_out_fore, n_out_fore;
    logic [COLOR_W-1:0]   r_out_back, n_out_back;
    logic [CUR_COL_W-1:0] r_out_col, n_out_col;
    logic [CUR_ROW_W-1:0] r_out_row, n_out_row;
    logic                 r_out_scroll, n_out_scroll;

    logic                 ram_we, ram_re, pop;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [CELL_W-1:0]    ram_wdata, ram_rdata;
    logic [CCW-1:0]       lim_col_m1;
    logic [RCW-1:0]       lim_row_m1;
    logic                 last_col, last_row;

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sweep limits: whole grid during the reset pass, active area otherwise
    assign lim_col_m1 = (r_state == BS_INIT) ? CCW'(MAX_COLS - 1) : i_cols - CCW'(1);
    assign lim_row_m1 = (r_state == BS_INIT) ? RCW'(MAX_ROWS - 1) : i_rows - RCW'(1);
    assign last_col   = (CCW'(r_col) == lim_col_m1);
    assign last_row   = (RCW'(r_row) == lim_row_m1);

    assign o_stat.init_done = (r_state != BS_INIT);
    assign o_stat.pop       = pop;

    // sequencer next state and memory control
    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_cmd        = r_cmd;
        n_wpend      = 1'b0;
        n_waddr      = r_waddr;
        n_out_valid  = r_out_valid;
        n_out_char   = r_out_char;
        n_out_fore   = r_out_fore;
        n_out_back   = r_out_back;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        n_out_scroll = r_out_scroll;
        pop          = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_waddr;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = AW'({r_row, r_col});

        // scroll copy lands in the cycle after its read
        if (r_wpend) begin
            ram_we    = 1'b1;
            ram_waddr = r_waddr;
            ram_wdata = ram_rdata;
        end

        if (i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            // zero fill, whole grid after reset or active area for clear
            BS_INIT, BS_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'({r_row, r_col});
                ram_wdata = '0;
                if (last_col) begin
                    n_col = '0;
                    if (last_row) begin
                        n_row   = '0;
                        n_state = (r_state == BS_INIT) ? BS_IDLE : BS_DONE;
                    end else begin
                        n_row = r_row + RW'(1);
                    end
                end else begin
                    n_col = r_col + XW'(1);
                end
            end
            // take a command, do its single cell access right away
            BS_IDLE: begin
                if (!i_q_stat.empty) begin
                    pop   = 1'b1;
                    n_cmd = i_head;
                    if (i_head.wr) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'({i_head.row[RW-1:0], i_head.col[XW-1:0]});
                        ram_wdata = {i_head.ch, i_head.fore, i_head.back};
                    end
                    if (i_head.rd) begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'({i_head.row[RW-1:0], i_head.col[XW-1:0]});
                    end
                    unique case (i_head.sweep)
                        SW_SCROLL: begin
                            n_col = '0;
                            if (i_rows == RCW'(1)) begin
                                n_row   = '0;
                                n_state = BS_ZERO;
                            end else begin
                                n_row   = RW'(i_rows - RCW'(2));
                                n_state = BS_COPY;
                            end
                        end
                        SW_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_state = BS_CLEAR;
                        end
                        default: n_state = BS_DONE;
                    endcase
                end
            end
            // read a row and write it one row up, top row first
            BS_COPY: begin
                ram_re    = 1'b1;
                ram_raddr = AW'({r_row, r_col});
                n_wpend   = 1'b1;
                n_waddr   = AW'({r_row + RW'(1), r_col});
                if (last_col) begin
                    n_col = '0;
                    if (r_row == '0) begin
                        n_state = BS_ZERO;
                    end else begin
                        n_row = r_row - RW'(1);
                    end
                end else begin
                    n_col = r_col + XW'(1);
                end
            end
            // blank the bottom row once the last copy has landed
            BS_ZERO: begin
                if (!r_wpend) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'({RW'(0), r_col});
                    ram_wdata = '0;
                    if (last_col) begin
                        n_col   = '0;
                        n_state = BS_DONE;
                    end else begin
                        n_col = r_col + XW'(1);
                    end
                end
            end
            // hand the result to the output register when it is free
            BS_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = r_cmd.rd ? ram_rdata[CELL_W-1 -: CHAR_W] : '0;
                    n_out_fore   = r_cmd.rd ? ram_rdata[2*COLOR_W-1 -: COLOR_W] : '0;
                    n_out_back   = r_cmd.rd ? ram_rdata[COLOR_W-1:0] : '0;
                    n_out_col    = r_cmd.cur_col;
                    n_out_row    = r_cmd.cur_row;
                    n_out_scroll = (r_cmd.sweep == SW_SCROLL);
                    n_state      = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_wpend     <= n_wpend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_waddr      <= n_waddr;
        r_out_char   <= n_out_char;
        r_out_fore   <= n_out_fore;
        r_out_back   <= n_out_back;
        r_out_col    <= n_out_col;
        r_out_row    <= n_out_row;
        r_out_scroll <= n_out_scroll;
    end

    assign o_valid      = r_out_valid;
    assign o_cell_char  = r_out_char;
    assign o_cell_fore  = r_out_fore;
    assign o_cell_back  = r_out_back;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_did_scroll = r_out_scroll;

endmodule

### design/text_console_cursor_scroll.sv
// top level of the character-cell text console with cursor and scroll
// uses tccs_pkg, tccs_front, tccs_queue, tccs_back and assert_macros.svh
`include "assert_macros.svh"

// The console keeps a MAX_ROWS x MAX_COLS grid of cells (character plus
// foreground and background color) in one simple dual-port RAM, and a cursor.
// After reset a clearing pass writes every cell, one per cycle, before the
// first request is taken. A front end accepts requests, updates the cursor
// and queues a command in a two-entry queue; it takes a request every cycle
// while the queue has room. The back-end sequencer, with its single RAM write
// port, runs one command at a time: put, write and read do their cell access
// and then hand over the result, clear zero-fills the active area, and a put
// that scrolls copies each row one row up, one cell per cycle, then blanks the
// bottom row. A finished result waits in an output register so the next
// request can start, but its result waits until the register is free.
module text_console_cursor_scroll import tccs_pkg::*; #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [CP_W-1:0]       i_code_point,
    input  logic [RSEL_W-1:0]     i_row_sel,
    input  logic [CSEL_W-1:0]     i_col_sel,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAR_W-1:0]     o_cell_char,
    output logic [COLOR_W-1:0]    o_cell_fore,
    output logic [COLOR_W-1:0]    o_cell_back,
    output logic [CUR_COL_W-1:0]  o_cursor_col,
    output logic [CUR_ROW_W-1:0]  o_cursor_row,
    output logic                  o_did_scroll
);

    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);

    logic [5:0]         r_rows_in_use;
    logic [7:0]         r_cols_in_use;
    logic [COLOR_W-1:0] r_text_color;
    logic [COLOR_W-1:0] r_back_color;
    logic [RCW-1:0]     rows_eff;
    logic [CCW-1:0]     cols_eff;

    logic       q_push;
    t_cmd       q_in, q_head;
    t_q_stat    qstat;
    t_back_stat bstat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= ROWS_RESET;
            r_cols_in_use <= COLS_RESET;
            r_text_color  <= TEXT_RESET;
            r_back_color  <= BACK_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_ROWS: r_rows_in_use <= i_cfg_data[5:0];
                REG_COLS: r_cols_in_use <= i_cfg_data[7:0];
                REG_TEXT: r_text_color  <= i_cfg_data;
                REG_BACK: r_back_color  <= i_cfg_data;
            endcase
        end
    end

    // active size clamped to the grid, a size of zero taken as one
    always_comb begin
        priority if (r_rows_in_use == '0) begin
            rows_eff = RCW'(1);
        end else if (32'(r_rows_in_use) > 32'(MAX_ROWS)) begin
            rows_eff = RCW'(MAX_ROWS);
        end else begin
            rows_eff = RCW'(r_rows_in_use);
        end
        priority if (r_cols_in_use == '0) begin
            cols_eff = CCW'(1);
        end else if (32'(r_cols_in_use) > 32'(MAX_COLS)) begin
            cols_eff = CCW'(MAX_COLS);
        end else begin
            cols_eff = CCW'(r_cols_in_use);
        end
    end

    tccs_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_opcode     (i_opcode),
        .i_code_point (i_code_point),
        .i_row_sel    (i_row_sel),
        .i_col_sel    (i_col_sel),
        .i_rows       (rows_eff),
        .i_cols       (cols_eff),
        .i_text_color (r_text_color),
        .i_back_color (r_back_color),
        .i_q_stat     (qstat),
        .i_init_done  (bstat.init_done),
        .o_push       (q_push),
        .o_cmd        (q_in)
    );

    tccs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (bstat.pop),
        .o_head  (q_head),
        .o_stat  (qstat)
    );

    tccs_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_q_stat     (qstat),
        .i_rows       (rows_eff),
        .i_cols       (cols_eff),
        .o_stat       (bstat),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_cell_char  (o_cell_char),
        .o_cell_fore  (o_cell_fore),
        .o_cell_back  (o_cell_back),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_did_scroll (o_did_scroll)
    );

    // checks
    `ASSERT_ALWAYS(a_queue_sane, !(qstat.full && qstat.empty), "queue full and empty at once")
    `ASSERT_IMPLY(a_pop_nonempty, bstat.pop, !qstat.empty, "command taken from empty queue")
    `ASSERT_IMPLY(a_init_quiet, !bstat.init_done, qstat.empty && !o_out_valid, "work during clearing pass")
    `ASSERT_NEXT(a_init_once, bstat.init_done, bstat.init_done, "clearing pass restarted")
    `ASSERT_IMPLY(a_scroll_home, o_out_valid && o_did_scroll, o_cursor_col == '0 && o_cursor_row == '0, "scroll with cursor off home")

endmodule

### test/text_console_cursor_scroll_test.sv
// testbench for the text console: directed and random requests, every result
// checked against a cell-level prediction of the grid, cursor and scrolling
// depends on tccs_pkg and the text_console_cursor_scroll top level
module text_console_cursor_scroll_test;
    import tccs_pkg::*;

    localparam int GRID_ROWS  = 32;
    localparam int GRID_COLS  = 128;
    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
    localparam int MAX_IDLE   = 16;
    localparam int N_PHASES   = 16;
    localparam int PHASE_LEN  = 120;
    localparam int BIG_LEN    = 60;
    localparam int SETTLE     = 16;
    localparam int LONG_HOLD  = 300;
    localparam int MAX_SHOWN  = 40;
    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

    // one result as seen on the output port
    typedef struct packed {
        logic [CHAR_W-1:0]    ch;
        logic [COLOR_W-1:0]   fore;
        logic [COLOR_W-1:0]   back;
        logic [CUR_COL_W-1:0] col;
        logic [CUR_ROW_W-1:0] row;
        logic                 scrolled;
    } t_cell_report;

    // grid and cursor prediction plus the queue of expected results
    class console_scoreboard;
        logic [CHAR_W-1:0]  ch_mem   [GRID_CELLS];
        logic [COLOR_W-1:0] fore_mem [GRID_CELLS];
        logic [COLOR_W-1:0] back_mem [GRID_CELLS];
        int unsigned        cur_x;
        int unsigned        cur_y;
        logic [5:0]         rows_reg;
        logic [7:0]         cols_reg;
        logic [COLOR_W-1:0] text_reg;
        logic [COLOR_W-1:0] back_reg;
        t_cell_report       expected_q[$];
        int                 errors;

        function new();
            for (int i = 0; i < GRID_CELLS; i++) begin
                ch_mem[i]   = '0;
                fore_mem[i] = '0;
                back_mem[i] = '0;
            end
            rows_reg = ROWS_RESET;
            cols_reg = COLS_RESET;
            text_reg = TEXT_RESET;
            back_reg = BACK_RESET;
            cur_x    = 0;
            cur_y    = rows_active() - 1;
            errors   = 0;
        endfunction

        function int unsigned rows_active();
            int unsigned r;
            r = rows_reg;
            if (r < 1) r = 1;
            if (r > GRID_ROWS) r = GRID_ROWS;
            return r;
        endfunction

        function int unsigned cols_active();
            int unsigned c;
            c = cols_reg;
            if (c < 1) c = 1;
            if (c > GRID_COLS) c = GRID_COLS;
            return c;
        endfunction

        function void set_reg(t_reg idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_ROWS: rows_reg = value[5:0];
                REG_COLS: cols_reg = value[7:0];
                REG_TEXT: text_reg = value;
                REG_BACK: back_reg = value;
                default: ;
            endcase
        endfunction

        function void fill_cell(int unsigned r, int unsigned c, logic [CHAR_W-1:0] ch,
                                logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
            int unsigned idx;
            idx = r * GRID_COLS + c;
            if (idx < GRID_CELLS) begin
                ch_mem[idx]   = ch;
                fore_mem[idx] = fg;
                back_mem[idx] = bg;
            end
        endfunction

        // stores nothing outside the active area; space is kept as empty
        function void store_char(logic [CP_W-1:0] cp, int unsigned r, int unsigned c);
            logic [CHAR_W-1:0] ch;
            if (r >= rows_active() || c >= cols_active()) return;
            ch = cp[CHAR_W-1:0];
            if (ch == CH_SPACE) ch = '0;
            fill_cell(r, c, ch, text_reg, back_reg);
        endfunction

        // every active row moves up one, bottom row becomes empty
        function void scroll_grid();
            int unsigned rows;
            int unsigned cols;
            int unsigned d;
            rows = rows_active();
            cols = cols_active();
            for (int r = rows - 1; r > 0; r--) begin
                for (int c = 0; c < cols; c++) begin
                    d = r * GRID_COLS + c;
                    ch_mem[d]   = ch_mem[d - GRID_COLS];
                    fore_mem[d] = fore_mem[d - GRID_COLS];
                    back_mem[d] = back_mem[d - GRID_COLS];
                end
            end
            for (int c = 0; c < cols; c++) fill_cell(0, c, '0, '0, '0);
        endfunction

        function void clear_grid();
            for (int r = 0; r < rows_active(); r++)
                for (int c = 0; c < cols_active(); c++) fill_cell(r, c, '0, '0, '0);
            cur_x = 0;
            cur_y = rows_active() - 1;
        endfunction

        // tab, return or a plain character at the cursor, then wrap and scroll
        function bit put_char(logic [CP_W-1:0] cp);
            int unsigned cols;
            bit          scrolled;
            cols     = cols_active();
            scrolled = 1'b0;
            if (cp == CP_TAB) begin
                cur_x = ((cur_x + 3) / 4) * 4;
            end else if (cp == CP_RETURN) begin
                cur_x = cols + 1;
            end else begin
                store_char(cp, cur_y, cur_x);
                cur_x++;
            end
            if (cur_x >= cols) begin
                cur_x = 0;
                if (cur_y == 0) begin
                    scroll_grid();
                    scrolled = 1'b1;
                end else begin
                    cur_y--;
                end
            end
            return scrolled;
        endfunction

        function void note_request(t_op op, logic [CP_W-1:0] cp, logic [RSEL_W-1:0] rs,
                                   logic [CSEL_W-1:0] cs);
            t_cell_report exp;
            int unsigned  idx;
            exp = '0;
            case (op)
                OP_PUT:   exp.scrolled = put_char(cp);
                OP_WRITE: store_char(cp, rs, cs);
                OP_CLEAR: clear_grid();
                OP_READ: begin
                    if (rs < rows_active() && cs < cols_active()) begin
                        idx      = rs * GRID_COLS + cs;
                        exp.ch   = ch_mem[idx];
                        exp.fore = fore_mem[idx];
                        exp.back = back_mem[idx];
                    end
                end
                default: ;
            endcase
            exp.col = cur_x[CUR_COL_W-1:0];
            exp.row = cur_y[CUR_ROW_W-1:0];
            expected_q.push_back(exp);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            if (errors < MAX_SHOWN)
                $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(t_cell_report got);
            t_cell_report exp;
            if (expected_q.size() == 0) begin
                report("result with no request waiting", 0, 0);
                return;
            end
            exp = expected_q.pop_front();
            if (got.ch !== exp.ch)             report("cell_char", got.ch, exp.ch);
            if (got.fore !== exp.fore)         report("cell_fore", got.fore, exp.fore);
            if (got.back !== exp.back)         report("cell_back", got.back, exp.back);
            if (got.col !== exp.col)           report("cursor_col", got.col, exp.col);
            if (got.row !== exp.row)           report("cursor_row", got.row, exp.row);
            if (got.scrolled !== exp.scrolled) report("did_scroll", got.scrolled, exp.scrolled);
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_opcode;
    logic [CP_W-1:0]       i_code_point;
    logic [RSEL_W-1:0]     i_row_sel;
    logic [CSEL_W-1:0]     i_col_sel;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [CHAR_W-1:0]     o_cell_char;
    logic [COLOR_W-1:0]    o_cell_fore;
    logic [COLOR_W-1:0]    o_cell_back;
    logic [CUR_COL_W-1:0]  o_cursor_col;
    logic [CUR_ROW_W-1:0]  o_cursor_row;
    logic                  o_did_scroll;

    console_scoreboard sb;
    bit                in_calm;
    bit                out_calm;
    int                hold_cycles;

    text_console_cursor_scroll #(
        .MAX_ROWS(GRID_ROWS),
        .MAX_COLS(GRID_COLS)
    ) uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one request: random gap unless in_calm, then hold it until accepted
    task automatic send_request(t_op op, logic [CP_W-1:0] cp, logic [RSEL_W-1:0] rs,
                                logic [CSEL_W-1:0] cs);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_code_point <= cp;
        i_row_sel    <= rs;
        i_col_sel    <= cs;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(op, cp, rs, cs);
    endtask

    // mostly puts, writes and reads aimed at the active area
    task automatic send_random(bit clear_ok);
        int unsigned      rows;
        int unsigned      cols;
        int               pick;
        t_op              op;
        logic [CP_W-1:0]  cp;
        logic [RSEL_W-1:0] rs;
        logic [CSEL_W-1:0] cs;
        rows = sb.rows_active();
        cols = sb.cols_active();
        pick = $urandom_range(0, 99);
        if (pick < 45)                     op = OP_PUT;
        else if (pick < 65)                op = OP_WRITE;
        else if (pick < 95 || !clear_ok)   op = OP_READ;
        else                               op = OP_CLEAR;
        case ($urandom_range(0, 9))
            0:       cp = CP_TAB;
            1:       cp = CP_RETURN;
            2:       cp = CP_W'(CH_SPACE);
            3:       cp = $urandom_range(0, CP_MAX);
            default: cp = $urandom_range(33, 126);
        endcase
        if ($urandom_range(0, 4) == 0)
            rs = $urandom_range(0, GRID_ROWS - 1);
        else
            rs = $urandom_range(0, (rows < GRID_ROWS) ? rows : rows - 1);
        if ($urandom_range(0, 4) == 0)
            cs = $urandom_range(0, GRID_COLS - 1);
        else
            cs = $urandom_range(0, (cols < GRID_COLS) ? cols : cols - 1);
        send_request(op, cp, rs, cs);
    endtask

    // drop valid and wait until every result is back and the block has settled
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_registers(logic [5:0] rows, logic [7:0] cols,
                                 logic [COLOR_W-1:0] text, logic [COLOR_W-1:0] back);
        logic [CFG_DATA_W-1:0] vals [4];
        vals[REG_ROWS] = CFG_DATA_W'(rows);
        vals[REG_COLS] = CFG_DATA_W'(cols);
        vals[REG_TEXT] = text;
        vals[REG_BACK] = back;
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_reg'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.set_reg(t_reg'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int           stall;
        t_cell_report got;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = out_calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got.ch       = o_cell_char;
            got.fore     = o_cell_fore;
            got.back     = o_cell_back;
            got.col      = o_cursor_col;
            got.row      = o_cursor_row;
            got.scrolled = o_did_scroll;
            sb.check_result(got);
        end
    end

    // main sequence
    initial begin
        int n_items;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_ROWS;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_PUT;
        i_code_point = '0;
        i_row_sel    = '0;
        i_col_sel    = '0;
        in_calm      = 1'b0;
        out_calm     = 1'b0;
        hold_cycles  = 0;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed checks at the reset size of 26 rows by 68 columns
        send_request(OP_READ, '0, 0, 0);
        send_request(OP_WRITE, CP_MAX, 25, 67);
        send_request(OP_READ, '0, 25, 67);
        send_request(OP_WRITE, CP_W'(CH_SPACE), 0, 0);
        send_request(OP_READ, '0, 0, 0);
        // writes just past the active rows and columns are dropped
        send_request(OP_WRITE, 21'h141, 26, 0);
        send_request(OP_WRITE, 21'h142, 0, 68);
        send_request(OP_READ, '0, 26, 0);
        send_request(OP_READ, '0, 31, 127);
        // tab from a multiple of four stays, return wraps a row down
        send_request(OP_PUT, 21'd65, 0, 0);
        send_request(OP_PUT, CP_TAB, 0, 0);
        send_request(OP_PUT, CP_TAB, 0, 0);
        send_request(OP_PUT, CP_RETURN, 0, 0);
        // codes that only look like tab or space after truncation
        send_request(OP_PUT, CP_TAB | 21'h100, 0, 0);
        send_request(OP_PUT, 21'h120, 0, 0);
        send_request(OP_READ, '0, 24, 0);
        send_request(OP_READ, '0, 24, 1);
        send_request(OP_READ, '0, 25, 0);
        send_request(OP_CLEAR, '0, 0, 0);
        send_request(OP_READ, '0, 25, 0);
        send_request(OP_READ, '0, 25, 67);
        wait_idle();

        // random phases, each at its own grid size and colors
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       set_registers(6'd0, 8'd0, 32'h0, 32'hFFFF_FFFF);
                1:       set_registers(6'd1, 8'd128, 32'hFFFF_FFFF, 32'h0);
                2:       set_registers(6'd32, 8'd4, $urandom, $urandom);
                3:       set_registers(6'd63, 8'd255, $urandom, $urandom);
                default: set_registers($urandom_range(0, 8), $urandom_range(0, 24),
                                       $urandom, $urandom);
            endcase
            in_calm  = (p % 4 == 2) || (p == 4);
            out_calm = (p % 5 == 3);
            // results held back long enough to fill the block
            if (p == 4) hold_cycles = LONG_HOLD;
            n_items = (p == 3) ? BIG_LEN : PHASE_LEN;
            for (int i = 0; i < n_items; i++) begin
                if (p == 5 && i == n_items / 2) wait_idle();
                send_random(p != 3);
            end
            wait_idle();
        end

        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/tccs_pkg.sv
design/tccs_ram.sv
design/tccs_front.sv
design/tccs_queue.sv
design/tccs_back.sv
design/text_console_cursor_scroll.sv
test/text_console_cursor_scroll_test.sv
